FILE: hw/rtl/tlb_page_table_translator_top_macros.svh
// assertion macros for the tlb page table translator
// used by tlb_page_table_translator_top; expects clk and rst_n in scope
`ifndef TLB_PAGE_TABLE_TRANSLATOR_TOP_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_TOP_MACROS_SVH

// condition must never be true outside reset
`define TPT_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// same-cycle implication
`define TPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/tpt_pkg.sv
// shared types and constants of the tlb page table translator
// no dependencies
package tpt_pkg;

    localparam int ADDR_W          = 16;
    localparam int PAGE_BITS       = 8;
    localparam int OFFSET_BITS     = 8;
    localparam int FRAME_W         = 8;
    localparam int NFF_W           = 9;
    localparam int PAGE_COUNT      = 1 << PAGE_BITS;
    localparam int TLB_ENTRIES_DEF = 16;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } tpt_state_t;

    // per-cell control from the chain controller
    typedef struct packed {
        logic valid;
        logic shift;
        logic load;
    } cell_ctl_t;

    // page table request: read at accept, commit on a tlb miss
    typedef struct packed {
        logic                 rd_en;
        logic [PAGE_BITS-1:0] rd_page;
        logic [PAGE_BITS-1:0] lk_page;
        logic                 commit;
    } pt_req_t;

    typedef struct packed {
        logic               fault;
        logic [FRAME_W-1:0] frame;
    } pt_resp_t;

endpackage

FILE: hw/rtl/tpt_cell.sv
// one tlb entry of the lru chain: holds a page and its frame
// depends on tpt_pkg
module tpt_cell (
    input  logic                          clk,
    input  tpt_pkg::cell_ctl_t            ctl,
    input  logic [tpt_pkg::PAGE_BITS-1:0] key_page,
    input  logic [tpt_pkg::PAGE_BITS-1:0] new_page,
    input  logic [tpt_pkg::FRAME_W-1:0]   new_frame,
    input  logic [tpt_pkg::PAGE_BITS-1:0] nbr_page,
    input  logic [tpt_pkg::FRAME_W-1:0]   nbr_frame,
    output logic [tpt_pkg::PAGE_BITS-1:0] page,
    output logic [tpt_pkg::FRAME_W-1:0]   frame,
    output logic                          match,
    output logic [tpt_pkg::FRAME_W-1:0]   hit_frame
);
    import tpt_pkg::*;

    logic [PAGE_BITS-1:0] page_reg;
    logic [FRAME_W-1:0]   frame_reg;

    // newest entry goes to the tail, entries above a removed one move down
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            page_reg  <= new_page;
            frame_reg <= new_frame;
        end
        else if (ctl.shift)
        begin
            page_reg  <= nbr_page;
            frame_reg <= nbr_frame;
        end
    end

    assign page      = page_reg;
    assign frame     = frame_reg;
    assign match     = ctl.valid && (page_reg == key_page);
    assign hit_frame = match ? frame_reg : '0;

endmodule

FILE: hw/rtl/tpt_page_table.sv
// page table: present bits in flops, frame store in memory, free frame counter
// depends on tpt_pkg
module tpt_page_table (
    input  logic              clk,
    input  logic              rst_n,
    input  tpt_pkg::pt_req_t  req,
    output tpt_pkg::pt_resp_t resp
);
    import tpt_pkg::*;

    logic [PAGE_COUNT-1:0] present_reg;
    logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
    logic [FRAME_W-1:0]    rd_data_reg;
    logic [NFF_W-1:0]      nff_reg;
    logic                  present;
    logic                  alloc;

    assign present = present_reg[req.lk_page];
    assign alloc   = req.commit && !present;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            nff_reg     <= '0;
        end
        else if (alloc)
        begin
            present_reg[req.lk_page] <= 1'b1;
            nff_reg                  <= nff_reg + NFF_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            frame_mem[req.lk_page] <= nff_reg[FRAME_W-1:0];
        end
        if (req.rd_en)
        begin
            rd_data_reg <= frame_mem[req.rd_page];
        end
    end

    assign resp.fault = !present;
    assign resp.frame = present ? rd_data_reg : nff_reg[FRAME_W-1:0];

endmodule

FILE: hw/rtl/tlb_page_table_translator_top.sv
// Address translator with a fully associative LRU TLB and a demand-paged page table.
// Each logical address is handled in ST_IDLE, which registers the address and starts the
// read of the page table frame memory, then in ST_LOOKUP, which matches the page against
// the chain of TLB cells, resolves hit, page table or new frame, and updates cells, page
// table and free frame counter. The next address is taken once that lookup completes, so
// none is accepted while one is in flight; the lookup holds while the result register is
// full and stalled. Page faults hand out frames in order, wrapping modulo 256.
// depends on tpt_pkg, tpt_cell, tpt_page_table and the macros header
module tlb_page_table_translator_top #(
    parameter int TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        addr_valid,
    output logic                        addr_stall,
    input  logic [tpt_pkg::ADDR_W-1:0]  virt_addr,
    output logic                        xlat_valid,
    input  logic                        xlat_stall,
    output logic [tpt_pkg::ADDR_W-1:0]  physical_address,
    output logic [tpt_pkg::FRAME_W-1:0] frame_number,
    output logic                        tlb_hit,
    output logic                        page_fault
);
    import tpt_pkg::*;

    `include "tlb_page_table_translator_top_macros.svh"

    localparam int FILL_W = $clog2(TLB_ENTRIES + 1);
    localparam int POS_W  = $clog2(TLB_ENTRIES);

    tpt_state_t state_reg, state_next;

    logic [ADDR_W-1:0]      addr_reg;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   out_valid_reg;
    logic [ADDR_W-1:0]      phys_reg;
    logic [FRAME_W-1:0]     frame_reg;
    logic                   hit_reg;
    logic                   fault_reg;

    logic                   accept;
    logic                   advance;
    logic [PAGE_BITS-1:0]   page_q;
    logic [OFFSET_BITS-1:0] offset_q;

    logic [PAGE_BITS-1:0]   cell_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0]     cell_frame [TLB_ENTRIES];
    logic [FRAME_W-1:0]     cell_hit_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] match;
    cell_ctl_t              cell_ctl [TLB_ENTRIES];

    logic                   hit;
    logic [POS_W-1:0]       hit_pos;
    logic [FRAME_W-1:0]     tlb_frame;
    logic                   drop;
    logic [POS_W-1:0]       drop_pos;
    logic [FILL_W-1:0]      tail;
    logic [FRAME_W-1:0]     frame;
    logic                   fault;

    pt_req_t                pt_req;
    pt_resp_t               pt_resp;

    assign page_q   = addr_reg[ADDR_W-1 -: PAGE_BITS];
    assign offset_q = addr_reg[OFFSET_BITS-1:0];

    // control
    always_comb
    begin
        state_next = state_reg;
        addr_stall = 1'b1;
        accept     = 1'b0;
        advance    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                addr_stall = 1'b0;
                accept     = addr_valid;
                if (addr_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                advance = !out_valid_reg || !xlat_stall;
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!xlat_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= virt_addr;
        end
        if (advance)
        begin
            phys_reg  <= ADDR_W'({frame, offset_q});
            frame_reg <= frame;
            hit_reg   <= hit;
            fault_reg <= fault;
        end
    end

    // tlb match reduction; pages in the tlb are unique so at most one cell matches
    always_comb
    begin
        hit_pos   = '0;
        tlb_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            if (match[i])
            begin
                hit_pos = hit_pos | POS_W'(i);
            end
            tlb_frame = tlb_frame | cell_hit_frame[i];
        end
    end

    assign hit      = |match;
    assign drop     = hit || (fill_reg == FILL_W'(TLB_ENTRIES));
    assign drop_pos = hit ? hit_pos : '0;
    assign tail     = drop ? (fill_reg - FILL_W'(1)) : fill_reg;
    assign frame    = hit ? tlb_frame : pt_resp.frame;
    assign fault    = !hit && pt_resp.fault;

    always_comb
    begin
        fill_next = fill_reg;
        if (advance && !drop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < TLB_ENTRIES; gi++)
        begin : g_cell
            logic [PAGE_BITS-1:0] nbr_page;
            logic [FRAME_W-1:0]   nbr_frame;

            assign cell_ctl[gi].valid = FILL_W'(gi) < fill_reg;
            assign cell_ctl[gi].shift = advance && drop && (POS_W'(gi) >= drop_pos)
                                        && (FILL_W'(gi) < tail);
            assign cell_ctl[gi].load  = advance && (FILL_W'(gi) == tail);

            if (gi == TLB_ENTRIES - 1)
            begin : g_last
                // the last cell never shifts; tie its neighbor input off
                assign nbr_page  = page_q;
                assign nbr_frame = frame;
            end
            else
            begin : g_mid
                assign nbr_page  = cell_page[gi+1];
                assign nbr_frame = cell_frame[gi+1];
            end

            tpt_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[gi]),
                .key_page  (page_q),
                .new_page  (page_q),
                .new_frame (frame),
                .nbr_page  (nbr_page),
                .nbr_frame (nbr_frame),
                .page      (cell_page[gi]),
                .frame     (cell_frame[gi]),
                .match     (match[gi]),
                .hit_frame (cell_hit_frame[gi])
            );
        end
    endgenerate

    assign pt_req.rd_en   = accept;
    assign pt_req.rd_page = virt_addr[ADDR_W-1 -: PAGE_BITS];
    assign pt_req.lk_page = page_q;
    assign pt_req.commit  = advance && !hit;

    tpt_page_table u_page_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pt_req),
        .resp  (pt_resp)
    );

    assign xlat_valid       = out_valid_reg;
    assign physical_address = phys_reg;
    assign frame_number     = frame_reg;
    assign tlb_hit          = hit_reg;
    assign page_fault       = fault_reg;

    `TPT_ASSERT_IMP(a_single_match, state_reg == ST_LOOKUP, $onehot0(match), "multiple tlb matches")
    `TPT_ASSERT_NEVER(a_fill_bound, fill_reg > FILL_W'(TLB_ENTRIES), "tlb fill count too large")
    `TPT_ASSERT_NEVER(a_hit_and_fault, xlat_valid && tlb_hit && page_fault, "hit with fault")
    `TPT_ASSERT_NEXT(a_result_loaded, advance, xlat_valid && state_reg == ST_IDLE, "no result")
    `TPT_ASSERT_NEXT(a_fill_steady_on_hit, advance && hit, fill_reg == $past(fill_reg), "fill moved")

endmodule
